// ===== sv/rdd_pkg.sv =====
// shared types and constants of the depth image decoder
`timescale 1ns / 1ps

package rdd_pkg;

  // configuration register indexes
  localparam int unsigned RegNumPixels = 0;

  // reset value of the pixel count register (640 x 480)
  localparam logic [23:0] NumPixelsReset = 24'd307200;

  // code word geometry
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned NibblesWord = 8;

  // what the next completed code means
  typedef enum logic [1:0] {
    PH_ZERO_CNT = 2'd0,
    PH_RUN_CNT  = 2'd1,
    PH_PIXEL    = 2'd2
  } rdd_phase_e;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic [23:0] repeat_count;
    logic        image_end;
    logic        decode_error;
    logic        last;
  } rdd_result_t;

endpackage

// ===== sv/rdd_fifo.sv =====
// small word queue between the accepting front and the decode engine
`timescale 1ns / 1ps

module rdd_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign ready_o    = (count_q != CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== sv/rdd_engine.sv =====
// decode engine: one nibble a cycle unless stalled, result hold stage and output register
`timescale 1ns / 1ps

module rdd_engine
  import rdd_pkg::*;
#(
  parameter int unsigned CountWidth = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [23:0]          num_pixels_i,
  input  logic                 word_valid_i,
  input  logic [WordWidth-1:0] word_i,
  output logic                 word_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rdd_result_t          out_o
);

  localparam int unsigned MaxGroups = CountWidth / 3;

  // word being taken apart
  logic [WordWidth-1:0] word_q;
  logic                 word_v_q;
  logic [2:0]           idx_q;

  // decoder state
  rdd_phase_e            phase_q, phase_d;
  logic [CountWidth-1:0] acc_q, acc_d;
  logic [3:0]            group_q, group_d;
  logic [23:0]           run_q, run_d;
  logic [15:0]           prev_q, prev_d;
  logic [23:0]           pl_q, pl_d;
  logic                  end_pend_q, end_pend_d;

  // result waiting to learn whether it closes its word
  rdd_result_t hold_q;
  logic        hold_v_q, hold_fin_q;

  rdd_result_t out_q, out_d;
  logic        out_v_q;

  logic                  step_en, out_free, push_res, push_fin, out_load;
  logic                  res_v, done, new_img, over;
  rdd_result_t           res;
  logic [3:0]            nib;
  logic [4:0]            sh;
  logic [CountWidth-1:0] acc_new;
  logic [32:0]           v_ext;
  logic [23:0]           pl_sub;
  logic [23:0]           run_dec;
  logic [15:0]           mag, delta, prev_new;

  assign out_free = !out_v_q || out_ready_i;
  assign step_en  = word_v_q && (!hold_v_q || out_free);

  // nibbles go from bit 31 down
  assign nib     = 4'(word_q >> {~idx_q, 2'b00});
  assign sh      = 5'(group_q) * 5'd3;
  assign acc_new = acc_q | (CountWidth'(nib[2:0]) << sh);
  assign v_ext   = 33'(acc_new);
  assign over    = v_ext > 33'(pl_q);
  assign pl_sub  = pl_q - v_ext[23:0];
  assign run_dec = run_q - 24'd1;
  assign mag      = v_ext[16:1];
  assign delta    = v_ext[0] ? ~mag : mag;
  assign prev_new = prev_q + delta;

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    group_d    = group_q;
    run_d      = run_q;
    prev_d     = prev_q;
    pl_d       = pl_q;
    end_pend_d = end_pend_q;
    res_v      = 1'b0;
    res        = '0;
    new_img    = 1'b0;
    done       = 1'b0;
    if (end_pend_q) begin
      // image closed by the last pixel of a run
      res_v         = 1'b1;
      res.image_end = 1'b1;
      new_img       = 1'b1;
    end else begin
      done = (idx_q == 3'd7);
      if (nib[3]) begin
        if (({1'b0, group_q} + 5'd1) >= 5'(MaxGroups)) begin
          // code too long
          res_v            = 1'b1;
          res.image_end    = 1'b1;
          res.decode_error = 1'b1;
          new_img          = 1'b1;
        end else begin
          group_d = group_q + 4'd1;
          acc_d   = acc_new;
        end
      end else begin
        acc_d   = '0;
        group_d = '0;
        case (phase_q)
          PH_RUN_CNT: begin
            if (over) begin
              res_v            = 1'b1;
              res.image_end    = 1'b1;
              res.decode_error = 1'b1;
              new_img          = 1'b1;
            end else begin
              pl_d = pl_sub;
              if (v_ext == '0) begin
                if (pl_sub == '0) begin
                  res_v         = 1'b1;
                  res.image_end = 1'b1;
                  new_img       = 1'b1;
                end else begin
                  phase_d = PH_ZERO_CNT;
                end
              end else begin
                run_d   = v_ext[23:0];
                phase_d = PH_PIXEL;
              end
            end
          end
          PH_PIXEL: begin
            prev_d           = prev_new;
            res_v            = 1'b1;
            res.pixel_value  = prev_new;
            res.repeat_count = 24'd1;
            run_d            = run_dec;
            if (run_dec == '0) begin
              // end marker goes out from end_pend_q when the engine steps again, the word stays until then
              if (pl_q == '0) begin
                end_pend_d = 1'b1;
                done       = 1'b0;
              end else begin
                phase_d = PH_ZERO_CNT;
              end
            end
          end
          default: begin
            if (over) begin
              res_v            = 1'b1;
              res.image_end    = 1'b1;
              res.decode_error = 1'b1;
              new_img          = 1'b1;
            end else begin
              pl_d             = pl_sub;
              res_v            = (v_ext != '0);
              res.repeat_count = v_ext[23:0];
              phase_d          = PH_RUN_CNT;
            end
          end
        endcase
      end
    end
    if (new_img) begin
      phase_d    = PH_ZERO_CNT;
      acc_d      = '0;
      group_d    = '0;
      run_d      = '0;
      prev_d     = '0;
      pl_d       = num_pixels_i;
      end_pend_d = 1'b0;
      done       = 1'b1;
    end
  end

  assign push_res   = step_en && res_v && hold_v_q;
  assign push_fin   = hold_v_q && hold_fin_q && out_free && !(step_en && res_v);
  assign out_load   = push_res || push_fin;
  assign word_pop_o = word_valid_i && (!word_v_q || (step_en && done));

  // held result with its last flag settled
  always_comb begin
    out_d      = hold_q;
    out_d.last = push_res ? hold_fin_q : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ZERO_CNT;
      acc_q      <= '0;
      group_q    <= '0;
      run_q      <= '0;
      prev_q     <= '0;
      pl_q       <= NumPixelsReset;
      end_pend_q <= 1'b0;
      word_v_q   <= 1'b0;
      idx_q      <= '0;
      hold_v_q   <= 1'b0;
      hold_fin_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (step_en) begin
        phase_q    <= phase_d;
        acc_q      <= acc_d;
        group_q    <= group_d;
        run_q      <= run_d;
        prev_q     <= prev_d;
        pl_q       <= pl_d;
        end_pend_q <= end_pend_d;
      end
      if (word_pop_o) begin
        word_v_q <= 1'b1;
        idx_q    <= '0;
      end else if (step_en && done) begin
        word_v_q <= 1'b0;
      end else if (step_en && !end_pend_q) begin
        idx_q <= idx_q + 3'd1;
      end
      if (step_en && res_v) begin
        hold_v_q   <= 1'b1;
        hold_fin_q <= done;
      end else if (push_fin) begin
        hold_v_q <= 1'b0;
      end else if (step_en && done) begin
        hold_fin_q <= 1'b1;
      end
      if (out_load)         out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_pop_o)         word_q <= word_i;
    if (step_en && res_v)   hold_q <= res;
    if (out_load)           out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ===== sv/rvl_depth_decoder_core.sv =====
// top level of the run-length/variable-length depth image decoder
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid/tready             tdata = code word
//  m_axis    out        tvalid/tready             tdata, tuser, tlast = one result
//  apb       in/out     psel/penable/pready       num_pixels at byte address 0
//
// the engine takes a code word apart one nibble per cycle while not stalled; a word
// whose nibble closes an image with the last pixel of a run is held for the end marker
// the engine shares one result channel, so a word with nine results sends them in turn
// reset clears all control state and loads the pixel count with 307200
// a four-entry word queue lets the input keep flowing while results are stalled;
// the engine stops when its hold stage and the output register are both full
//
module rvl_depth_decoder_core
  import rdd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24,
  parameter int unsigned FIFO_DEPTH  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] code_word
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [15:0] pixel_value, [39:16] repeat_count
  output logic [1:0]  m_axis_tuser_o,   // [0] image_end, [1] decode_error
  output logic        m_axis_tlast_o,
  // configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [23:0]    num_pixels_q;
  logic           cfg_hit;

  logic           q_valid, q_pop;
  logic [31:0]    q_data;

  logic           res_valid;
  rdd_result_t    res;

  // register decode: bit 2 of the byte address selects the register
  assign cfg_hit  = (32'(paddr_i[2]) == RegNumPixels);
  assign pready_o = 1'b1;
  assign prdata_o = cfg_hit ? {8'd0, num_pixels_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pixels_q <= NumPixelsReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o && cfg_hit) begin
      num_pixels_q <= pwdata_i[23:0];
    end
  end

  // front: accept code words into the queue
  rdd_fifo #(
    .Depth (FIFO_DEPTH),
    .Width (WordWidth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (s_axis_tdata_i),
    .ready_o     (s_axis_tready_o),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // back: nibble decode and result delivery
  rdd_engine #(
    .CountWidth (COUNT_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_pixels_i (num_pixels_q),
    .word_valid_i (q_valid),
    .word_i       (q_data),
    .word_pop_o   (q_pop),
    .out_valid_o  (res_valid),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (res)
  );

  assign m_axis_tvalid_o = res_valid;
  assign m_axis_tdata_o  = {res.repeat_count, res.pixel_value};
  assign m_axis_tuser_o  = {res.decode_error, res.image_end};
  assign m_axis_tlast_o  = res.last;

endmodule
